// ----- rtl/jsvp_pkg.sv -----
// Package: types, codes and character helpers for the JSON value parser.
`timescale 1ns / 1ps

package jsvp_pkg;

    typedef enum logic [13:0] {
        PH_LEAD  = 14'b00000000000001,
        PH_LIT   = 14'b00000000000010,
        PH_MINUS = 14'b00000000000100,
        PH_ZERO  = 14'b00000000001000,
        PH_INT   = 14'b00000000010000,
        PH_DOT   = 14'b00000000100000,
        PH_FRAC  = 14'b00000001000000,
        PH_EMARK = 14'b00000010000000,
        PH_ESIGN = 14'b00000100000000,
        PH_EXP   = 14'b00001000000000,
        PH_STR   = 14'b00010000000000,
        PH_ESC   = 14'b00100000000000,
        PH_TRAIL = 14'b01000000000000,
        PH_ERR   = 14'b10000000000000
    } phase_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EXPECT    = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_NOT_SING  = 3'd3;
    localparam logic [2:0] ST_MISS_QUOT = 3'd4;
    localparam logic [2:0] ST_BAD_ESC   = 3'd5;
    localparam logic [2:0] ST_BAD_CHAR  = 3'd6;

    localparam logic [2:0] T_NULL   = 3'd0;
    localparam logic [2:0] T_FALSE  = 3'd1;
    localparam logic [2:0] T_TRUE   = 3'd2;
    localparam logic [2:0] T_NUMBER = 3'd3;
    localparam logic [2:0] T_STRING = 3'd4;

    localparam logic [1:0] KIND_STR    = 2'd0;
    localparam logic [1:0] KIND_NUM    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] LIT_NULL  = 2'd0;
    localparam logic [1:0] LIT_TRUE  = 2'd1;
    localparam logic [1:0] LIT_FALSE = 2'd2;

    typedef struct packed {
        phase_t     phase;
        logic [2:0] lit_pos;
        logic [1:0] lit_kind;
        logic [2:0] status;
        logic [2:0] found_type;
    } jsvp_state_t;

    localparam jsvp_state_t RESET_STATE = '{
        phase:      PH_LEAD,
        lit_pos:    3'd0,
        lit_kind:   LIT_NULL,
        status:     ST_OK,
        found_type: T_NULL
    };

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] value_type;
        logic [7:0] out_byte;
        logic [1:0] out_kind;
    } jsvp_result_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] k);
        return (k == LIT_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [2:0] lit_type(input logic [1:0] k);
        logic [2:0] t;
        case (k)
            LIT_TRUE:  t = T_TRUE;
            LIT_FALSE: t = T_FALSE;
            default:   t = T_NULL;
        endcase
        return t;
    endfunction

    // character p of "null", "true" or "false"
    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            LIT_TRUE:
                case (p)
                    3'd0:    c = 8'h74;
                    3'd1:    c = 8'h72;
                    3'd2:    c = 8'h75;
                    3'd3:    c = 8'h65;
                    default: c = 8'h00;
                endcase
            LIT_FALSE:
                case (p)
                    3'd0:    c = 8'h66;
                    3'd1:    c = 8'h61;
                    3'd2:    c = 8'h6C;
                    3'd3:    c = 8'h73;
                    3'd4:    c = 8'h65;
                    default: c = 8'h00;
                endcase
            default:
                case (p)
                    3'd0:    c = 8'h6E;
                    3'd1:    c = 8'h75;
                    3'd2:    c = 8'h6C;
                    3'd3:    c = 8'h6C;
                    default: c = 8'h00;
                endcase
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/jsvp_step.sv -----
// Next-state and result logic for one text byte or the end-of-text item.
`timescale 1ns / 1ps

module jsvp_step
    import jsvp_pkg::*;
(
    input  jsvp_state_t  cur,
    input  logic [7:0]   in_byte,
    input  logic         end_flag,
    output jsvp_state_t  nxt,
    output logic         res_valid,
    output jsvp_result_t res
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_F     = 8'h66;

    logic [7:0] b;
    logic       ws;
    logic       dig;
    logic       emark;
    logic [1:0] k;
    logic [2:0] p1;
    logic [2:0] st;
    logic [2:0] ft;

    assign b     = in_byte;
    assign ws    = is_ws(b);
    assign dig   = is_digit(b);
    assign emark = (b == CH_E_LO) || (b == CH_E_UP);
    assign k     = (cur.lit_kind == 2'd3) ? LIT_NULL : cur.lit_kind;
    assign p1    = cur.lit_pos + 3'd1;

    always_comb
    begin
        nxt       = cur;
        res_valid = 1'b0;
        res       = '0;
        st        = ST_INVALID;
        ft        = cur.found_type;

        if (end_flag)
        begin
            case (cur.phase)
                PH_LEAD:  st = ST_EXPECT;
                PH_ZERO, PH_INT, PH_FRAC, PH_EXP:
                begin
                    st = ST_OK;
                    ft = T_NUMBER;
                end
                PH_TRAIL: st = ST_OK;
                PH_STR:   st = ST_MISS_QUOT;
                PH_ESC:   st = ST_BAD_ESC;
                PH_ERR:   st = cur.status;
                default:  st = ST_INVALID;
            endcase
            nxt            = RESET_STATE;
            res_valid      = 1'b1;
            res.out_kind   = KIND_STATUS;
            res.status     = st;
            res.value_type = (st == ST_OK) ? ft : T_NULL;
        end
        else
        begin
            case (cur.phase)
                PH_LEAD:
                begin
                    if (ws)
                    begin
                        nxt.phase = PH_LEAD;
                    end
                    else if ((b == CH_N) || (b == CH_T) || (b == CH_F))
                    begin
                        nxt.lit_kind = (b == CH_N) ? LIT_NULL :
                                       (b == CH_T) ? LIT_TRUE : LIT_FALSE;
                        nxt.lit_pos  = 3'd1;
                        nxt.phase    = PH_LIT;
                    end
                    else if (b == CH_QUOTE)
                    begin
                        nxt.phase = PH_STR;
                    end
                    else if ((b == CH_MINUS) || dig)
                    begin
                        nxt.phase = (b == CH_MINUS) ? PH_MINUS :
                                    (b == CH_ZERO)  ? PH_ZERO  : PH_INT;
                        res_valid = 1'b1;
                    end
                    else
                    begin
                        nxt.status = ST_INVALID;
                        nxt.phase  = PH_ERR;
                    end
                end
                PH_LIT:
                begin
                    if ((cur.lit_pos >= lit_len(k)) || (b != lit_char(k, cur.lit_pos)))
                    begin
                        nxt.status = ST_INVALID;
                        nxt.phase  = PH_ERR;
                    end
                    else
                    begin
                        nxt.lit_pos = p1;
                        if (p1 == lit_len(k))
                        begin
                            nxt.found_type = lit_type(k);
                            nxt.phase      = PH_TRAIL;
                        end
                    end
                end
                PH_MINUS:
                begin
                    if (dig)
                    begin
                        nxt.phase = (b == CH_ZERO) ? PH_ZERO : PH_INT;
                        res_valid = 1'b1;
                    end
                    else
                    begin
                        nxt.status = ST_INVALID;
                        nxt.phase  = PH_ERR;
                    end
                end
                PH_ZERO, PH_INT, PH_FRAC, PH_EXP:
                begin
                    if (dig && (cur.phase != PH_ZERO))
                    begin
                        res_valid = 1'b1;
                    end
                    else if ((b == CH_DOT) &&
                             ((cur.phase == PH_ZERO) || (cur.phase == PH_INT)))
                    begin
                        nxt.phase = PH_DOT;
                        res_valid = 1'b1;
                    end
                    else if (emark && (cur.phase != PH_EXP))
                    begin
                        nxt.phase = PH_EMARK;
                        res_valid = 1'b1;
                    end
                    else if (ws)
                    begin
                        nxt.found_type = T_NUMBER;
                        nxt.phase      = PH_TRAIL;
                    end
                    else
                    begin
                        nxt.status     = ST_NOT_SING;
                        nxt.found_type = T_NULL;
                        nxt.phase      = PH_ERR;
                    end
                end
                PH_DOT, PH_ESIGN:
                begin
                    if (dig)
                    begin
                        nxt.phase = (cur.phase == PH_DOT) ? PH_FRAC : PH_EXP;
                        res_valid = 1'b1;
                    end
                    else
                    begin
                        nxt.status = ST_INVALID;
                        nxt.phase  = PH_ERR;
                    end
                end
                PH_EMARK:
                begin
                    if ((b == CH_PLUS) || (b == CH_MINUS))
                    begin
                        nxt.phase = PH_ESIGN;
                        res_valid = 1'b1;
                    end
                    else if (dig)
                    begin
                        nxt.phase = PH_EXP;
                        res_valid = 1'b1;
                    end
                    else
                    begin
                        nxt.status = ST_INVALID;
                        nxt.phase  = PH_ERR;
                    end
                end
                PH_STR:
                begin
                    if (b == CH_QUOTE)
                    begin
                        nxt.found_type = T_STRING;
                        nxt.phase      = PH_TRAIL;
                    end
                    else if (b == CH_BSL)
                    begin
                        nxt.phase = PH_ESC;
                    end
                    else if (b < 8'h20)
                    begin
                        nxt.status = ST_BAD_CHAR;
                        nxt.phase  = PH_ERR;
                    end
                    else
                    begin
                        res_valid    = 1'b1;
                        res.out_kind = KIND_STR;
                        res.out_byte = b;
                    end
                end
                PH_ESC:
                begin
                    res_valid    = 1'b1;
                    res.out_kind = KIND_STR;
                    nxt.phase    = PH_STR;
                    case (b)
                        8'h22:   res.out_byte = 8'h22;
                        8'h5C:   res.out_byte = 8'h5C;
                        8'h2F:   res.out_byte = 8'h2F;
                        8'h62:   res.out_byte = 8'h08;
                        8'h66:   res.out_byte = 8'h0C;
                        8'h6E:   res.out_byte = 8'h0A;
                        8'h72:   res.out_byte = 8'h0D;
                        8'h74:   res.out_byte = 8'h09;
                        default:
                        begin
                            res_valid  = 1'b0;
                            nxt.status = ST_BAD_ESC;
                            nxt.phase  = PH_ERR;
                        end
                    endcase
                end
                PH_TRAIL:
                begin
                    if (!ws)
                    begin
                        nxt.status     = ST_NOT_SING;
                        nxt.found_type = T_NULL;
                        nxt.phase      = PH_ERR;
                    end
                end
                PH_ERR:
                begin
                    nxt = cur;
                end
                default:
                begin
                    nxt.status = ST_INVALID;
                    nxt.phase  = PH_ERR;
                end
            endcase

            // number characters are echoed as they arrive
            if (res_valid && (cur.phase != PH_STR) && (cur.phase != PH_ESC))
            begin
                res.out_kind = KIND_NUM;
                res.out_byte = b;
            end
            if (nxt.phase == PH_ERR)
            begin
                nxt.found_type = T_NULL;
            end
        end
    end

endmodule

// ----- rtl/jsvp_out_buf.sv -----
// Two-entry output register with skid slot for result transfers.
`timescale 1ns / 1ps

module jsvp_out_buf
    import jsvp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  jsvp_result_t push_data,
    output logic         can_push,
    output logic         out_valid,
    input  logic         out_ready,
    output jsvp_result_t out_data
);

    logic         main_valid_reg;
    logic         skid_valid_reg;
    jsvp_result_t main_reg;
    jsvp_result_t skid_reg;
    logic         pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
    end

endmodule

// ----- rtl/json_single_value_parser.sv -----
// Top level: streaming validator for one JSON root value.
`timescale 1ns / 1ps

// Takes one JSON text byte per transfer and checks that it holds one value
// (null, true, false, number or string) with optional surrounding whitespace.
// The end of the text is marked by s_tlast on its own transfer, whose data
// byte is ignored. String bytes (escapes decoded) and number characters are
// emitted as they arrive; the end-of-text transfer emits the final status and
// value type and returns the parser to its start state. Discard emitted bytes
// unless the final status is ok. One byte is accepted every cycle while the
// output side keeps up; the parser state is updated by combinational logic
// and each result is registered in the output buffer. A two-entry output
// buffer lets input continue for one more result while the output side stalls.
module json_single_value_parser
    import jsvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] value_type, [13:11] status
    output logic [1:0]  m_tuser    // [1:0] out_kind
);

    jsvp_state_t  state_reg;
    jsvp_state_t  state_next;
    logic         res_valid;
    jsvp_result_t res;
    jsvp_result_t out_res;
    logic         accept;
    logic         push;

    assign accept = s_tvalid && s_tready;
    assign push   = accept && res_valid;

    jsvp_step u_step (
        .cur       (state_reg),
        .in_byte   (s_tdata),
        .end_flag  (s_tlast),
        .nxt       (state_next),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RESET_STATE;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    jsvp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .can_push  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {2'b00, out_res.status, out_res.value_type, out_res.out_byte};
    assign m_tuser = out_res.out_kind;

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (state_reg.phase == PH_LEAD))
        else $error("end of text did not restart the parser");

    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tlast && (state_reg.phase == PH_ERR)) |-> !push)
        else $error("result emitted after an error");

    a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((res.out_kind == KIND_STATUS) == s_tlast))
        else $error("final status not tied to end of text");

endmodule

// ----- dv/tb_top.sv -----
// Testbench: feeds JSON texts to the value parser and checks output transfers against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import jsvp_pkg::*;

    typedef struct packed {
        logic [7:0]   b;
        logic         eot;
        logic         typed;
        jsvp_result_t exp;
    } item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;    // [7:0] in_byte
    logic        s_tlast = 1'b0;     // end_of_text
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] out_byte, [10:8] value_type, [13:11] status
    logic [1:0]  m_tuser;            // [1:0] out_kind

    json_single_value_parser DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    phase_t     pp;
    logic [2:0] lpos;
    logic [1:0] lkind;
    logic [2:0] lstat;
    logic [2:0] vtype;

    string      words [3] = '{"null", "true", "false"};
    logic [2:0] word_type [3] = '{T_NULL, T_TRUE, T_FALSE};

    item_t        stim_q [$];
    jsvp_result_t pending_results [$];
    item_t        cur_item = '0;
    logic         quiet = 1'b0;
    int           sink_hold = 0;
    int           mismatches = 0;
    int           texts_done = 0;
    int           bytes_done = 0;
    int           results_checked = 0;
    int           ok_texts = 0;

    function automatic logic is_blank(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
    endfunction

    function automatic logic is_num_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic void parse_reset();
        pp    = PH_LEAD;
        lpos  = 3'd0;
        lkind = LIT_NULL;
        lstat = ST_OK;
        vtype = T_NULL;
    endfunction

    function automatic void parse_fail(input logic [2:0] code);
        lstat = code;
        vtype = T_NULL;
        pp    = PH_ERR;
    endfunction

    function automatic void number_end(input logic [7:0] b);
        vtype = T_NUMBER;
        if (is_blank(b))
            pp = PH_TRAIL;
        else
            parse_fail(ST_NOT_SING);
    endfunction

    // one byte or end marker; returns 1 when a result transfer is due
    function automatic bit parse_byte(input logic [7:0] b, input logic eot,
                                      output jsvp_result_t r);
        logic [2:0] st;
        logic [7:0] d;
        bit         emit;
        bit         esc_ok;
        logic [1:0] kind;
        r      = '0;
        emit   = 1'b0;
        esc_ok = 1'b1;
        kind   = KIND_NUM;
        d      = b;
        if (eot)
        begin
            case (pp)
                PH_LEAD:                          st = ST_EXPECT;
                PH_ZERO, PH_INT, PH_FRAC, PH_EXP:
                begin
                    vtype = T_NUMBER;
                    st    = ST_OK;
                end
                PH_TRAIL:                         st = ST_OK;
                PH_STR:                           st = ST_MISS_QUOT;
                PH_ESC:                           st = ST_BAD_ESC;
                PH_ERR:                           st = lstat;
                default:                          st = ST_INVALID;
            endcase
            r.out_kind   = KIND_STATUS;
            r.out_byte   = 8'h00;
            r.value_type = (st == ST_OK) ? vtype : T_NULL;
            r.status     = st;
            parse_reset();
            return 1'b1;
        end
        case (pp)
            PH_LEAD:
            begin
                if (is_blank(b))
                    emit = 1'b0;
                else if (b == "n" || b == "t" || b == "f")
                begin
                    lkind = (b == "n") ? LIT_NULL : (b == "t") ? LIT_TRUE : LIT_FALSE;
                    lpos  = 3'd1;
                    pp    = PH_LIT;
                end
                else if (b == "\"")
                    pp = PH_STR;
                else if (b == "-")
                begin
                    pp   = PH_MINUS;
                    emit = 1'b1;
                end
                else if (b == "0")
                begin
                    pp   = PH_ZERO;
                    emit = 1'b1;
                end
                else if (is_num_digit(b))
                begin
                    pp   = PH_INT;
                    emit = 1'b1;
                end
                else
                    parse_fail(ST_INVALID);
            end
            PH_LIT:
            begin
                if (lpos >= words[lkind].len() || b != words[lkind][lpos])
                    parse_fail(ST_INVALID);
                else
                begin
                    lpos = lpos + 3'd1;
                    if (lpos == words[lkind].len())
                    begin
                        vtype = word_type[lkind];
                        pp    = PH_TRAIL;
                    end
                end
            end
            PH_MINUS:
            begin
                if (b == "0")
                begin
                    pp   = PH_ZERO;
                    emit = 1'b1;
                end
                else if (is_num_digit(b))
                begin
                    pp   = PH_INT;
                    emit = 1'b1;
                end
                else
                    parse_fail(ST_INVALID);
            end
            PH_ZERO, PH_INT:
            begin
                if (pp == PH_INT && is_num_digit(b))
                    emit = 1'b1;
                else if (b == ".")
                begin
                    pp   = PH_DOT;
                    emit = 1'b1;
                end
                else if (b == "e" || b == "E")
                begin
                    pp   = PH_EMARK;
                    emit = 1'b1;
                end
                else
                    number_end(b);
            end
            PH_DOT:
            begin
                if (is_num_digit(b))
                begin
                    pp   = PH_FRAC;
                    emit = 1'b1;
                end
                else
                    parse_fail(ST_INVALID);
            end
            PH_FRAC:
            begin
                if (is_num_digit(b))
                    emit = 1'b1;
                else if (b == "e" || b == "E")
                begin
                    pp   = PH_EMARK;
                    emit = 1'b1;
                end
                else
                    number_end(b);
            end
            PH_EMARK:
            begin
                if (b == "+" || b == "-")
                begin
                    pp   = PH_ESIGN;
                    emit = 1'b1;
                end
                else if (is_num_digit(b))
                begin
                    pp   = PH_EXP;
                    emit = 1'b1;
                end
                else
                    parse_fail(ST_INVALID);
            end
            PH_ESIGN:
            begin
                if (is_num_digit(b))
                begin
                    pp   = PH_EXP;
                    emit = 1'b1;
                end
                else
                    parse_fail(ST_INVALID);
            end
            PH_EXP:
            begin
                if (is_num_digit(b))
                    emit = 1'b1;
                else
                    number_end(b);
            end
            PH_STR:
            begin
                if (b == "\"")
                begin
                    vtype = T_STRING;
                    pp    = PH_TRAIL;
                end
                else if (b == "\\")
                    pp = PH_ESC;
                else if (b < 8'h20)
                    parse_fail(ST_BAD_CHAR);
                else
                begin
                    kind = KIND_STR;
                    emit = 1'b1;
                end
            end
            PH_ESC:
            begin
                case (b)
                    "\"":    d = "\"";
                    "\\":    d = "\\";
                    "/":     d = "/";
                    "b":     d = 8'h08;
                    "f":     d = 8'h0C;
                    "n":     d = 8'h0A;
                    "r":     d = 8'h0D;
                    "t":     d = 8'h09;
                    default: esc_ok = 1'b0;
                endcase
                if (esc_ok)
                begin
                    pp   = PH_STR;
                    kind = KIND_STR;
                    emit = 1'b1;
                end
                else
                    parse_fail(ST_BAD_ESC);
            end
            PH_TRAIL:
            begin
                if (!is_blank(b))
                    parse_fail(ST_NOT_SING);
            end
            PH_ERR:
                emit = 1'b0;
            default:
                parse_fail(ST_INVALID);
        endcase
        if (emit)
        begin
            r.out_kind = kind;
            r.out_byte = d;
        end
        return emit;
    endfunction

    function automatic item_t text_byte(input logic [7:0] b);
        item_t it;
        it   = '0;
        it.b = b;
        return it;
    endfunction

    // end-of-text row; typed rows carry their expected status transfer
    function automatic item_t end_row(input logic typed, input logic [2:0] st,
                                      input logic [2:0] vt);
        item_t it;
        it                = '0;
        it.b              = 8'($urandom_range(0, 255));
        it.eot            = 1'b1;
        it.typed          = typed;
        it.exp.out_kind   = KIND_STATUS;
        it.exp.status     = st;
        it.exp.value_type = vt;
        return it;
    endfunction

    task automatic gen_text();
        logic [7:0] t [$];
        logic [7:0] c;
        string      w;
        int         sel;
        int         n;
        logic [7:0] blanks [4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};
        logic [7:0] escs [8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};
        repeat ($urandom_range(0, 2)) t.push_back(blanks[$urandom_range(0, 3)]);
        sel = $urandom_range(0, 2);
        case (sel)
            0:
            begin
                w = words[$urandom_range(0, 2)];
                for (int i = 0; i < w.len(); i++)
                    t.push_back(w[i]);
            end
            1:
            begin
                if ($urandom_range(0, 1))
                    t.push_back("-");
                if ($urandom_range(0, 3) == 0)
                    t.push_back("0");
                else
                begin
                    t.push_back(8'(8'h31 + $urandom_range(0, 8)));
                    repeat ($urandom_range(0, 3))
                        t.push_back(8'(8'h30 + $urandom_range(0, 9)));
                end
                if ($urandom_range(0, 1))
                begin
                    t.push_back(".");
                    repeat ($urandom_range(1, 3))
                        t.push_back(8'(8'h30 + $urandom_range(0, 9)));
                end
                if ($urandom_range(0, 1))
                begin
                    t.push_back($urandom_range(0, 1) ? "e" : "E");
                    n = $urandom_range(0, 2);
                    if (n == 1)
                        t.push_back("+");
                    else if (n == 2)
                        t.push_back("-");
                    repeat ($urandom_range(1, 3))
                        t.push_back(8'(8'h30 + $urandom_range(0, 9)));
                end
            end
            default:
            begin
                t.push_back("\"");
                repeat ($urandom_range(0, 6))
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        t.push_back("\\");
                        t.push_back(escs[$urandom_range(0, 7)]);
                    end
                    else
                    begin
                        c = 8'($urandom_range(32, 255));
                        if (c == "\"" || c == "\\")
                            c = "a";
                        t.push_back(c);
                    end
                end
                t.push_back("\"");
            end
        endcase
        repeat ($urandom_range(0, 2)) t.push_back(blanks[$urandom_range(0, 3)]);
        // mostly well-formed; the rest damaged, cut short, with junk, or noise
        sel = $urandom_range(0, 9);
        if (sel == 0)
            t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
        else if (sel == 1)
        begin
            n = $urandom_range(0, t.size() - 1);
            while (t.size() > n)
                void'(t.pop_back());
        end
        else if (sel == 2)
            t.push_back(8'($urandom_range(0, 255)));
        else if (sel == 3)
        begin
            t.delete();
            repeat ($urandom_range(1, 4)) t.push_back(8'($urandom_range(0, 255)));
        end
        foreach (t[i])
            stim_q.push_back(text_byte(t[i]));
        stim_q.push_back(end_row(1'b0, ST_OK, T_NULL));
    endtask

    initial
    begin
        item_t dir_tbl [0:25];
        int    n_dir;
        dir_tbl = '{
            end_row(1'b1, ST_EXPECT, T_NULL),
            text_byte(8'h20), end_row(1'b1, ST_EXPECT, T_NULL),
            text_byte(8'hFF), text_byte(8'h00), end_row(1'b1, ST_INVALID, T_NULL),
            text_byte("\""), text_byte("\\"), text_byte("u"),
            end_row(1'b1, ST_BAD_ESC, T_NULL),
            text_byte("\""), text_byte(8'hFF), text_byte(8'h00),
            end_row(1'b1, ST_BAD_CHAR, T_NULL),
            text_byte("\""), end_row(1'b1, ST_MISS_QUOT, T_NULL),
            text_byte("t"), text_byte("r"), end_row(1'b1, ST_INVALID, T_NULL),
            text_byte("-"), end_row(1'b1, ST_INVALID, T_NULL),
            text_byte("0"), text_byte("1"), end_row(1'b1, ST_NOT_SING, T_NULL),
            text_byte("0"), end_row(1'b1, ST_OK, T_NUMBER)
        };
        foreach (dir_tbl[i])
            stim_q.push_back(dir_tbl[i]);
        n_dir = stim_q.size();
        while (stim_q.size() < n_dir + 1200)
            gen_text();
        parse_reset();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < stim_q.size(); i++)
        begin
            if (i == stim_q.size() - 150)
                quiet <= 1'b1;
            if (i < stim_q.size() - 150 && $urandom_range(0, 7) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= stim_q[i].b;
            s_tlast  <= stim_q[i].eot;
            cur_item <= stim_q[i];
            do
                @(posedge clk);
            while (!s_tready);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("ran %0d texts (%0d bytes), %0d ended ok", texts_done, bytes_done, ok_texts);
        $display("checked %0d output transfers, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("json_single_value_parser: match");
        else
            $display("json_single_value_parser: mismatch");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("json_single_value_parser: mismatch");
        $finish;
    end

    // output side backpressure
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            m_tready  <= 1'b0;
            sink_hold <= $urandom_range(0, 13);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : scoreboard
        jsvp_result_t r;
        jsvp_result_t e;
        jsvp_result_t got;
        bit           has;
        if (rst_n && s_tvalid && s_tready)
        begin
            has = parse_byte(s_tdata, s_tlast, r);
            if (cur_item.typed)
                r = cur_item.exp;
            if (has)
                pending_results.push_back(r);
            if (s_tlast)
                texts_done++;
            else
                bytes_done++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status     = m_tdata[13:11];
            got.value_type = m_tdata[10:8];
            got.out_byte   = m_tdata[7:0];
            got.out_kind   = m_tuser;
            results_checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected transfer kind=%0d byte=%02h type=%0d status=%0d",
                             $realtime, got.out_kind, got.out_byte, got.value_type, got.status);
            end
            else
            begin
                e = pending_results.pop_front();
                if (got.out_kind === KIND_STATUS && got.status === ST_OK)
                    ok_texts++;
                if (got.out_kind !== e.out_kind || got.out_byte !== e.out_byte ||
                    got.value_type !== e.value_type || got.status !== e.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: exp kind=%0d byte=%02h type=%0d status=%0d, ",
                                  "got kind=%0d byte=%02h type=%0d status=%0d"},
                                 $realtime, e.out_kind, e.out_byte, e.value_type, e.status,
                                 got.out_kind, got.out_byte, got.value_type, got.status);
                end
            end
        end
    end

endmodule

// ----- sim.f -----
rtl/jsvp_pkg.sv
rtl/jsvp_step.sv
rtl/jsvp_out_buf.sv
rtl/json_single_value_parser.sv
dv/tb_top.sv
